// ===== rtl/rlkd_pkg.sv =====
// Package for the resistor-ladder keypad decoder: debounce phases, register
// indexes, reset values, default parameter values and shared structs.
// No dependencies.
package rlkd_pkg;

  // Default parameter values
  localparam int unsigned KEY_SLOTS_DEF   = 8;
  localparam int unsigned RING_DEPTH_DEF  = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned TOL_W   = 10;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 16;

  // Held key value meaning no key is pressed
  localparam logic [KEY_W-1:0] NO_KEY = 4'hF;

  // Register reset values
  localparam logic [KEY_W-1:0]      KEY_COUNT_RST   = 4'd8;
  localparam logic [TOL_W-1:0]      TOLERANCE_RST   = 10'd20;
  localparam logic [TICK_W-1:0]     DEBOUNCE_RST    = 8'd5;
  localparam logic [39:0]           LEVELS_LOW_RST  = 40'd485687003249;
  localparam logic [39:0]           LEVELS_HIGH_RST = 40'd971492727349;
  localparam logic [CFG_DATA_W-1:0] KEY_CODES_RST   = 64'd3978425819141910832;

  // Debounce phases, encoded as reported on the result
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_PRESS   = 3'd1,
    PH_PRESSED = 3'd2,
    PH_RELEASE = 3'd3,
    PH_STORE   = 3'd4
  } phase_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COUNT   = 3'd0,
    REG_TOLERANCE   = 3'd1,
    REG_DEBOUNCE    = 3'd2,
    REG_LEVELS_LOW  = 3'd3,
    REG_LEVELS_HIGH = 3'd4,
    REG_KEY_CODES   = 3'd5
  } cfg_idx_e;

  // Input item kind carried in tuser
  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Store request from the debounce machine
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } store_req_t;

  // Ring access control for one executed item
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [CODE_W-1:0] push_code;
  } ring_ctrl_t;

endpackage

// ===== rtl/rlkd_classify.sv =====
// Sample classifier: parallel window compares against the key levels, lowest
// matching key wins. Depends on rlkd_pkg.
module rlkd_classify
  import rlkd_pkg::*;
#(
  parameter int unsigned KEY_SLOTS   = KEY_SLOTS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic [KEY_W-1:0]         key_count_i,
  input  logic [TOL_W-1:0]         tolerance_i,
  input  logic [4*SAMPLE_BITS-1:0] levels_low_i,
  input  logic [4*SAMPLE_BITS-1:0] levels_high_i,
  output logic [KEY_W-1:0]         key_o
);

  localparam int unsigned CMP_W = (SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W;

  logic [KEY_SLOTS-1:0] hit;
  logic [CMP_W-1:0]     sample_w;
  logic [CMP_W-1:0]     tol_w;

  assign sample_w = CMP_W'(sample_i);
  assign tol_w    = CMP_W'(tolerance_i);

  // Window compare per key slot
  for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_slot
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS-1:0] diff;
    if (k < 4) begin : g_low
      assign level = levels_low_i[k*SAMPLE_BITS +: SAMPLE_BITS];
    end else begin : g_high
      assign level = levels_high_i[(k-4)*SAMPLE_BITS +: SAMPLE_BITS];
    end
    assign diff   = (sample_i > level) ? sample_i - level : level - sample_i;
    assign hit[k] = (key_count_i > KEY_W'(k)) && (CMP_W'(diff) < tol_w);
  end

  // Pick the lowest matching key; at or below tolerance means no press
  always_comb begin
    key_o = NO_KEY;
    if (sample_w > tol_w) begin
      for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
        if (hit[k]) begin
          key_o = KEY_W'(k);
        end
      end
    end
  end

endmodule

// ===== rtl/rlkd_debounce.sv =====
// Five-phase debounce machine with held key and tick counter; raises a store
// request in the store phase. Depends on rlkd_pkg.
module rlkd_debounce
  import rlkd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [KEY_W-1:0]  key_count_i,
  input  logic [TICK_W-1:0] debounce_ticks_i,
  output phase_e            phase_o,
  output store_req_t        store_o
);

  phase_e             phase_q, phase_d;
  logic [KEY_W-1:0]   held_q, held_d;
  logic [TICK_W-1:0]  tick_q, tick_d;

  // Next state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    tick_d  = tick_q;
    if (step_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          held_d = key_i;
          if (key_i != NO_KEY) begin
            tick_d  = debounce_ticks_i;
            phase_d = PH_PRESS;
          end
        end
        PH_PRESS: begin
          if (key_i == held_q) begin
            if (tick_q != '0) tick_d = tick_q - 1'b1;
            else              phase_d = PH_PRESSED;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_PRESSED: begin
          if (key_i == NO_KEY) begin
            phase_d = PH_RELEASE;
            tick_d  = debounce_ticks_i;
          end
        end
        PH_RELEASE: begin
          if (key_i == NO_KEY) begin
            if (tick_q != '0) tick_d = tick_q - 1'b1;
            else              phase_d = PH_STORE;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_STORE: phase_d = PH_IDLE;
        default:  phase_d = PH_IDLE;
      endcase
    end
  end

  // Outputs
  always_comb begin
    phase_o       = phase_d;
    store_o.key   = held_q;
    store_o.valid = step_i && (phase_q == PH_STORE) && (held_q != NO_KEY) &&
                    (held_q < key_count_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= NO_KEY;
      tick_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      tick_q  <= tick_d;
    end
  end

endmodule

// ===== rtl/rlkd_ring.sv =====
// Code ring: synchronous memory with two registered read ports that fetch the
// head and the entry after it, per-entry valid bits, pointers and write
// forwarding. Depends on rlkd_pkg.
module rlkd_ring
  import rlkd_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_ctrl_t        ctrl_i,
  output logic [CODE_W-1:0] head_code_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

  logic [CODE_W-1:0]     mem_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q, valid_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d, rd_next;
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d, wr_next;
  logic [CODE_W-1:0]     rd_a_q, rd_b_q, rd_sel;
  logic                  adv_q, adv_d;
  logic                  fwd_v_q;
  logic [PTR_W-1:0]      fwd_addr_q;
  logic [CODE_W-1:0]     fwd_data_q;

  assign rd_next = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
  assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;

  // Resolve the head: pick the port matching the pointer, then forward
  always_comb begin
    rd_sel = adv_q ? rd_b_q : rd_a_q;
    if (fwd_v_q && (fwd_addr_q == rd_ptr_q)) begin
      rd_sel = fwd_data_q;
    end
    head_code_o = valid_q[rd_ptr_q] ? rd_sel : '0;
  end

  // Pop and push bookkeeping
  always_comb begin
    valid_d  = valid_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    adv_d    = 1'b0;
    if (ctrl_i.pop && (head_code_o != '0)) begin
      valid_d[rd_ptr_q] = 1'b0;
      rd_ptr_d          = rd_next;
      adv_d             = 1'b1;
    end
    if (ctrl_i.push) begin
      valid_d[wr_ptr_q] = 1'b1;
      wr_ptr_d          = wr_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      adv_q    <= 1'b0;
      fwd_v_q  <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      adv_q    <= adv_d;
      fwd_v_q  <= ctrl_i.push;
    end
  end

  // Forwarding payload for a write that the same-edge read misses
  always_ff @(posedge clk_i) begin
    fwd_addr_q <= wr_ptr_q;
    fwd_data_q <= ctrl_i.push_code;
  end

  // Memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_ptr_q] <= ctrl_i.push_code;
    end
    rd_a_q <= mem_q[rd_ptr_q];
    rd_b_q <= mem_q[rd_next];
  end

endmodule

// ===== rtl/resistor_ladder_keypad_decoder_top.sv =====
// Top level of the resistor-ladder keypad decoder: configuration registers,
// execute stage, output register. Depends on rlkd_pkg, rlkd_classify,
// rlkd_debounce and rlkd_ring.

// The block takes one item per clock cycle, scan ticks and reads in any mix,
// and gives one result per item, registered through the execute stage and the
// output register. The transfer edge also registers the code ring memory reads
// at the head and at the entry after it; the execute stage then classifies the
// sample, steps the debounce machine, pops or stores a code and loads the output
// register. A stalled result holds the execute stage, and the input waits only
// while both the execute stage and the output register are full. The ring clears
// at reset through per-entry valid bits, so items are taken from the first cycle
// after reset. Configuration writes are taken in any cycle (cfg_ready_o is always
// high) and belong between items, while the block is idle.
module resistor_ladder_keypad_decoder_top
  import rlkd_pkg::*;
#(
  parameter int unsigned KEY_SLOTS   = KEY_SLOTS_DEF,
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // adc_sample, zero pad
  input  logic                              s_axis_tuser,  // op
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_DATA_W-1:0]             m_axis_tdata,  // key_code, debounce_phase, pad
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [CFG_DATA_W-1:0]             cfg_data_i
);

  localparam int unsigned LEVEL_W = 4 * SAMPLE_BITS;

  // Configuration registers
  logic [KEY_W-1:0]      key_count_q;
  logic [TOL_W-1:0]      tolerance_q;
  logic [TICK_W-1:0]     debounce_q;
  logic [LEVEL_W-1:0]    levels_low_q;
  logic [LEVEL_W-1:0]    levels_high_q;
  logic [CFG_DATA_W-1:0] key_codes_q;

  // Execute stage and output register
  logic                   s1_v_q;
  logic                   s1_op_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   out_v_q;
  logic [CODE_W-1:0]      out_code_q;
  logic [PHASE_W-1:0]     out_phase_q;

  logic              exec;
  logic              accept;
  logic [KEY_W-1:0]  cls_key;
  phase_e            phase_next;
  store_req_t        store_req;
  ring_ctrl_t        ring_ctrl;
  logic [CODE_W-1:0] head_code;

  assign cfg_ready_o   = 1'b1;
  assign exec          = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || exec;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q   <= KEY_COUNT_RST;
      tolerance_q   <= TOLERANCE_RST;
      debounce_q    <= DEBOUNCE_RST;
      levels_low_q  <= LEVEL_W'(LEVELS_LOW_RST);
      levels_high_q <= LEVEL_W'(LEVELS_HIGH_RST);
      key_codes_q   <= KEY_CODES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KEY_COUNT:   key_count_q   <= cfg_data_i[KEY_W-1:0];
        REG_TOLERANCE:   tolerance_q   <= cfg_data_i[TOL_W-1:0];
        REG_DEBOUNCE:    debounce_q    <= cfg_data_i[TICK_W-1:0];
        REG_LEVELS_LOW:  levels_low_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_LEVELS_HIGH: levels_high_q <= cfg_data_i[LEVEL_W-1:0];
        REG_KEY_CODES:   key_codes_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rlkd_classify #(
    .KEY_SLOTS   (KEY_SLOTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_classify (
    .sample_i      (s1_sample_q),
    .key_count_i   (key_count_q),
    .tolerance_i   (tolerance_q),
    .levels_low_i  (levels_low_q),
    .levels_high_i (levels_high_q),
    .key_o         (cls_key)
  );

  rlkd_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (exec && (s1_op_q == OP_SCAN)),
    .key_i            (cls_key),
    .key_count_i      (key_count_q),
    .debounce_ticks_i (debounce_q),
    .phase_o          (phase_next),
    .store_o          (store_req)
  );

  // Drive the ring for the executing item
  always_comb begin
    ring_ctrl.pop       = exec && (s1_op_q == OP_READ);
    ring_ctrl.push      = store_req.valid;
    ring_ctrl.push_code = key_codes_q[8*store_req.key[2:0] +: 8];
  end

  rlkd_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ring_ctrl),
    .head_code_o (head_code)
  );

  // Advance the execute stage and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept)    s1_v_q <= 1'b1;
      else if (exec) s1_v_q <= 1'b0;
      if (exec)               out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= s_axis_tuser;
      s1_sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (exec) begin
      out_code_q  <= (s1_op_q == OP_READ) ? head_code : '0;
      out_phase_q <= phase_next;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-CODE_W-PHASE_W){1'b0}}, out_phase_q, out_code_q};

endmodule

// ===== rtl/rlkd_checker.sv =====
// Port-level checker for the keypad decoder result stream, bound to the top
// level. Depends on rlkd_pkg.
module rlkd_checker
  import rlkd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic               xfer;
  logic               seen_q;
  logic [PHASE_W-1:0] last_phase_q;
  logic [PHASE_W-1:0] phase;

  assign xfer  = m_axis_tvalid && m_axis_tready;
  assign phase = m_axis_tdata[CODE_W +: PHASE_W];

  // Track the phase of the previous result transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_phase_q <= PH_IDLE;
    end else if (xfer) begin
      seen_q       <= 1'b1;
      last_phase_q <= phase;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped under stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed under stall");

  a_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && seen_q && (last_phase_q == PH_IDLE) |->
      (phase == PH_IDLE) || (phase == PH_PRESS))
    else $error("idle can only stay or enter press debounce");

  a_from_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && seen_q && (last_phase_q == PH_PRESS) |->
      (phase == PH_IDLE) || (phase == PH_PRESS) || (phase == PH_PRESSED))
    else $error("press debounce skipped ahead");

  a_from_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && seen_q && (last_phase_q == PH_STORE) |->
      (phase == PH_IDLE) || (phase == PH_STORE))
    else $error("store phase did not return to idle");

endmodule

bind resistor_ladder_keypad_decoder_top rlkd_checker u_rlkd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/resistor_ladder_keypad_decoder_top_tb.sv =====
// Self-checking testbench for the resistor-ladder keypad decoder top level.
// Depends on rlkd_pkg and resistor_ladder_keypad_decoder_top; a built-in
// predictor of the debounce machine and code ring checks every result.
module resistor_ladder_keypad_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlkd_pkg::*;

  localparam int unsigned SAMPLE_W       = SAMPLE_BITS_DEF;
  localparam int unsigned RING           = RING_DEPTH_DEF;
  localparam int unsigned IN_DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
  localparam realtime     CLK_PERIOD     = 12ns;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] sample;
  } ladder_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    phase_e            phase;
  } keypad_result_t;

  typedef struct packed {
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // DUT connections, all inputs known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // adc_sample, zero pad
  logic                  s_axis_tuser  = 1'b0; // op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // key_code, debounce_phase, pad
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Stimulus and expectation stores
  ladder_item_t   ladder_item_q[$];
  keypad_result_t keypad_result_q[$];
  reg_write_t     reg_write_q[$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned read_pct     = 0;
  int unsigned fail_count   = 0;

  // Predictor copy of the configuration
  logic [KEY_W-1:0]      cfg_key_count = KEY_COUNT_RST;
  logic [TOL_W-1:0]      cfg_tolerance = TOLERANCE_RST;
  logic [TICK_W-1:0]     cfg_debounce  = DEBOUNCE_RST;
  logic [39:0]           cfg_levels_lo = LEVELS_LOW_RST;
  logic [39:0]           cfg_levels_hi = LEVELS_HIGH_RST;
  logic [CFG_DATA_W-1:0] cfg_key_codes = KEY_CODES_RST;

  // Predictor copy of the keypad state
  phase_e            kp_phase = PH_IDLE;
  logic [KEY_W-1:0]  kp_held  = NO_KEY;
  logic [TICK_W-1:0] kp_ticks = '0;
  logic [CODE_W-1:0] kp_ring[RING];
  int unsigned       kp_wr    = 0;
  int unsigned       kp_rd    = 0;

  resistor_ladder_keypad_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int keys_in_use();
    return (cfg_key_count > KEY_SLOTS_DEF) ? KEY_SLOTS_DEF : int'(cfg_key_count);
  endfunction

  function automatic int level_of(int k);
    if (k < 4) return int'(cfg_levels_lo[SAMPLE_W*k +: SAMPLE_W]);
    return int'(cfg_levels_hi[SAMPLE_W*(k-4) +: SAMPLE_W]);
  endfunction

  // First key whose level lies strictly inside the window; a sample at or
  // below the tolerance is no press
  function automatic logic [KEY_W-1:0] decode_key(logic [SAMPLE_W-1:0] sample);
    int a;
    int gap;
    logic [KEY_W-1:0] found;
    a     = int'(sample);
    found = NO_KEY;
    if (sample > cfg_tolerance) begin
      for (int k = keys_in_use() - 1; k >= 0; k--) begin
        gap = (a > level_of(k)) ? a - level_of(k) : level_of(k) - a;
        if (gap < int'(cfg_tolerance)) found = KEY_W'(k);
      end
    end
    return found;
  endfunction

  // Advance the debounce machine or pop the ring, then queue the result
  task automatic ladder_step(op_e op, logic [SAMPLE_W-1:0] sample);
    logic [KEY_W-1:0] key;
    keypad_result_t   res;
    res.code = '0;
    if (op == OP_READ) begin
      res.code = kp_ring[kp_rd];
      if (res.code != '0) begin
        kp_ring[kp_rd] = '0;
        kp_rd = (kp_rd == RING - 1) ? 0 : kp_rd + 1;
      end
    end else begin
      key = decode_key(sample);
      case (kp_phase)
        PH_IDLE: begin
          kp_held = key;
          if (key != NO_KEY) begin
            kp_ticks = cfg_debounce;
            kp_phase = PH_PRESS;
          end
        end
        PH_PRESS: begin
          if (key == kp_held) begin
            if (kp_ticks != '0) kp_ticks = kp_ticks - 1'b1;
            else kp_phase = PH_PRESSED;
          end else begin
            kp_phase = PH_IDLE;
          end
        end
        PH_PRESSED: begin
          if (key == NO_KEY) begin
            kp_phase = PH_RELEASE;
            kp_ticks = cfg_debounce;
          end
        end
        PH_RELEASE: begin
          if (key == NO_KEY) begin
            if (kp_ticks != '0) kp_ticks = kp_ticks - 1'b1;
            else kp_phase = PH_STORE;
          end else begin
            kp_phase = PH_IDLE;
          end
        end
        default: begin
          // Key count may have shrunk since the press; store only a key in use
          if (kp_held != NO_KEY && int'(kp_held) < keys_in_use()) begin
            kp_ring[kp_wr] = cfg_key_codes[8*kp_held +: 8];
            kp_wr = (kp_wr == RING - 1) ? 0 : kp_wr + 1;
          end
          kp_phase = PH_IDLE;
        end
      endcase
    end
    res.phase = kp_phase;
    keypad_result_q.push_back(res);
  endtask

  task automatic apply_reg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_KEY_COUNT:   cfg_key_count = data[KEY_W-1:0];
      REG_TOLERANCE:   cfg_tolerance = data[TOL_W-1:0];
      REG_DEBOUNCE:    cfg_debounce  = data[TICK_W-1:0];
      REG_LEVELS_LOW:  cfg_levels_lo = data[39:0];
      REG_LEVELS_HIGH: cfg_levels_hi = data[39:0];
      REG_KEY_CODES:   cfg_key_codes = data;
      default: ;
    endcase
  endtask

  // Driver: item stream and register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ladder_step(op_e'(s_axis_tuser), s_axis_tdata[SAMPLE_W-1:0]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ladder_item_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= ladder_item_q[0].op;
          s_axis_tdata  <= IN_DATA_W'(ladder_item_q[0].sample);
          ladder_item_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg_write(cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_write_q.size() > 0) begin
          cfg_valid_i <= 1'b1;
          cfg_index_i <= reg_write_q[0].idx;
          cfg_data_i  <= reg_write_q[0].data;
          reg_write_q.pop_front();
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (keypad_result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected result code %0h phase %0d", $realtime,
                     m_axis_tdata[7:0], m_axis_tdata[10:8]);
        end else begin
          if (m_axis_tdata[7:0] !== keypad_result_q[0].code ||
              m_axis_tdata[10:8] !== keypad_result_q[0].phase) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: mismatch code exp %0h got %0h, phase exp %0d got %0d",
                       $realtime, keypad_result_q[0].code, m_axis_tdata[7:0],
                       keypad_result_q[0].phase, m_axis_tdata[10:8]);
          end
          keypad_result_q.pop_front();
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Stimulus helpers; all run at the falling edge

  function automatic logic [SAMPLE_W-1:0] sample_near(int k);
    int lv;
    int lo;
    int hi;
    lv = level_of(k);
    lo = lv - int'(cfg_tolerance) + 1;
    hi = lv + int'(cfg_tolerance) - 1;
    if (lo < 0) lo = 0;
    if (hi > 1023) hi = 1023;
    if (lo > hi) return SAMPLE_W'(lv);
    return SAMPLE_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_quiet();
    return SAMPLE_W'($urandom_range(int'(cfg_tolerance), 0));
  endfunction

  function automatic logic [39:0] pack_levels(int l0, int l1, int l2, int l3);
    return {l3[9:0], l2[9:0], l1[9:0], l0[9:0]};
  endfunction

  task automatic add_item(op_e op, logic [SAMPLE_W-1:0] sample);
    ladder_item_t it;
    it.op     = op;
    it.sample = sample;
    ladder_item_q.push_back(it);
  endtask

  // Scan tick, sometimes preceded by a read
  task automatic add_scan(logic [SAMPLE_W-1:0] sample);
    if ($urandom_range(99) < read_pct) add_item(OP_READ, SAMPLE_W'($urandom_range(1023)));
    add_item(OP_SCAN, sample);
  endtask

  task automatic queue_hold(int k, int ticks);
    for (int i = 0; i < ticks; i++) add_scan(sample_near(k));
  endtask

  task automatic queue_quiet(int ticks);
    for (int i = 0; i < ticks; i++) add_scan(sample_quiet());
  endtask

  function automatic int pick_key();
    if ($urandom_range(9) == 0) return $urandom_range(7);
    return $urandom_range(keys_in_use() - 1);
  endfunction

  // Mostly clean presses, mixed with bounces and noise
  task automatic fill_random_phase(int target);
    int d;
    int k;
    int r;
    d = int'(cfg_debounce);
    while (ladder_item_q.size() < target) begin
      r = $urandom_range(99);
      k = pick_key();
      if (r < 65) begin
        queue_hold(k, d + 2 + $urandom_range(2));
        queue_quiet(d + 3 + $urandom_range(1));
      end else if (r < 75) begin
        // bounce during press debounce
        queue_hold(k, $urandom_range(d + 1, 1));
        queue_quiet(1);
      end else if (r < 85) begin
        // bounce during release debounce
        queue_hold(k, d + 2);
        queue_quiet($urandom_range(d + 1, 1));
        queue_hold(k, 1);
        queue_quiet(d + 3);
      end else begin
        repeat ($urandom_range(4, 1)) add_scan(SAMPLE_W'($urandom_range(1023)));
      end
    end
  endtask

  task automatic wait_drained();
    while (ladder_item_q.size() != 0 || s_axis_tvalid || keypad_result_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_regs(int kc, int tol, int db, logic [39:0] lo, logic [39:0] hi,
                            logic [63:0] codes);
    reg_write_t w;
    w.idx = REG_KEY_COUNT;   w.data = 64'(kc);  reg_write_q.push_back(w);
    w.idx = REG_TOLERANCE;   w.data = 64'(tol); reg_write_q.push_back(w);
    w.idx = REG_DEBOUNCE;    w.data = 64'(db);  reg_write_q.push_back(w);
    w.idx = REG_LEVELS_LOW;  w.data = 64'(lo);  reg_write_q.push_back(w);
    w.idx = REG_LEVELS_HIGH; w.data = 64'(hi);  reg_write_q.push_back(w);
    w.idx = REG_KEY_CODES;   w.data = codes;    reg_write_q.push_back(w);
    while (reg_write_q.size() != 0 || cfg_valid_i) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_pace(int tx, int rx, int rd);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    read_pct     = rd;
  endtask

  initial begin
    logic [63:0] codes;
    logic [39:0] lo;
    logic [39:0] hi;
    int          d;

    for (int i = 0; i < RING; i++) kp_ring[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset configuration, empty read, boundaries, one full press
    set_pace(0, 0, 0);
    add_item(OP_READ, '0);
    add_item(OP_SCAN, '0);
    add_item(OP_SCAN, 10'h3FF);
    add_item(OP_SCAN, 10'd20);
    add_item(OP_SCAN, 10'd133);
    add_item(OP_SCAN, 10'd885);
    for (int i = 0; i < 6; i++) add_item(OP_SCAN, 10'd923);
    for (int i = 0; i < 4; i++) add_item(OP_SCAN, 10'd0);
    add_item(OP_READ, '0);
    for (int i = 0; i < 4; i++) add_item(OP_SCAN, 10'd20);
    add_item(OP_READ, 10'h3FF);
    add_item(OP_READ, '0);
    wait_drained();

    // Fast debounce, reset levels, nonzero codes
    codes = {$urandom(), $urandom()} | 64'h0101_0101_0101_0101;
    write_regs(8, 20, 0, LEVELS_LOW_RST, LEVELS_HIGH_RST, codes);
    set_pace(55, 0, 20);
    fill_random_phase(40);
    wait_drained();

    // Spaced levels, zero codes on two keys; leave key 6 held at the end
    codes = {$urandom(), $urandom()} & 64'hFFFF_FF00_FFFF_00FF;
    write_regs(8, 40, 2, pack_levels(100, 210, 320, 430), pack_levels(540, 650, 760, 870),
               codes);
    set_pace(0, 55, 30);
    fill_random_phase(40);
    queue_hold(6, 4);
    wait_drained();

    // Shrink key count under the held key, then release; few reads fill the ring
    codes = {$urandom(), $urandom()};
    write_regs(3, 30, 1, pack_levels(100, 210, 320, 430), pack_levels(540, 650, 760, 870),
               codes);
    set_pace(27, 27, 5);
    queue_quiet(4);
    fill_random_phase(80);
    wait_drained();

    // Zero tolerance: nothing can match
    write_regs(1, 0, 0, '0, '0, '0);
    set_pace(0, 0, 25);
    fill_random_phase(20);
    wait_drained();

    // Full tolerance: every sample counts as no press
    write_regs(8, 1023, 0, '1, '1, '1);
    set_pace(55, 0, 20);
    fill_random_phase(20);
    wait_drained();

    // Longest debounce, keys 4-7 at full scale
    write_regs(8, 60, 255, LEVELS_LOW_RST, '1, '1);
    set_pace(27, 27, 2);
    d = 255;
    queue_hold(4, d + 3);
    queue_quiet(d + 4);
    add_item(OP_READ, '0);
    wait_drained();

    // Random overlapping levels
    lo = {$urandom(), $urandom()};
    hi = {$urandom(), $urandom()};
    codes = {$urandom(), $urandom()};
    write_regs(5, $urandom_range(100, 10), $urandom_range(3), lo, hi, codes);
    set_pace(0, 55, 15);
    fill_random_phase(40);
    wait_drained();

    // Random key count and tolerance, then drain the ring
    lo = {$urandom(), $urandom()};
    hi = {$urandom(), $urandom()};
    codes = {$urandom(), $urandom()};
    write_regs($urandom_range(8, 1), $urandom_range(120, 5), 1, lo, hi, codes);
    set_pace(0, 0, 35);
    fill_random_phase(50);
    repeat (RING + 2) add_item(OP_READ, SAMPLE_W'($urandom_range(1023)));
    wait_drained();

    if (fail_count == 0 && keypad_result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
